>>> hw/rtl/efce_pkg.sv
// ============================================================================
// Escaped frame CRC-32 encoder package
// Shared constants, the command passed from front to back, and byte helpers.
// ============================================================================
package efce_pkg;

    // Framing bytes.
    localparam logic [7:0] START_BYTE  = 8'hA5;
    localparam logic [7:0] ESCAPE_BYTE = 8'h5A;

    // CRC-32, MSB first, no reflection.
    localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
    localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
    localparam int          CRC_BYTES = 4;
    localparam int          CRC_IDX_W = $clog2(CRC_BYTES);

    // Frames are padded to a multiple of this many bytes.
    localparam int FRAME_ALIGN = 4;
    localparam int PHASE_W     = $clog2(FRAME_ALIGN);

    // Request codes on the input channel.
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Command kinds queued between the front and the back.
    typedef enum logic {
        CMD_START,
        CMD_PAYLOAD
    } t_cmd_kind;

    // One classified item, ready for byte generation.
    typedef struct packed {
        t_cmd_kind  kind;
        logic       close;   // frame ends after this item
        logic [7:0] len;
        logic [2:0] addr;
        logic [7:0] seq;
        logic [7:0] data;
    } t_cmd;

    // A byte that collides with a framing byte needs an escape prefix.
    function automatic logic f_need_escape(input logic [7:0] b);
        return (b == START_BYTE) || (b == ESCAPE_BYTE);
    endfunction

    // Advance the CRC register over one byte.
    function automatic logic [31:0] f_crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h000000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/efce_if.sv
// ============================================================================
// Escaped frame CRC-32 encoder channel interfaces
// Valid/ready channels for request items and for wire stream bytes.
// ============================================================================

// Request channel: start items and payload bytes.
interface efce_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] payload_length;
    logic [2:0] sender_address;
    logic [7:0] data_byte;

    modport source (output valid, req_type, payload_length, sender_address, data_byte,
                    input ready);
    modport sink   (input valid, req_type, payload_length, sender_address, data_byte,
                    output ready);
endinterface

// Result channel: one wire byte per transfer.
interface efce_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, out_byte, last_of_run, frame_end, input ready);
    modport sink   (input valid, out_byte, last_of_run, frame_end, output ready);
endinterface

>>> hw/rtl/escaped_frame_crc32_encoder_top.sv
// ============================================================================
// Escaped frame CRC-32 encoder
// Builds byte-stuffed frames with a CRC-32 trailer and zero padding.
// ============================================================================
// Usage:
//   i_in carries request items: a start item (header fields) or one payload
//   byte. o_out carries the wire stream one byte per transfer; last_of_run
//   marks the last byte caused by an item and frame_end the frame's last byte.
//   The front end takes one item per cycle while its two-entry command queue
//   has room; a payload item with no open frame is dropped there.
//   The back end emits one byte per cycle while the receiver takes them; a
//   payload byte causes 1 or 2 bytes, a header 4 to 6, and a frame end adds 4
//   to 8 for the CRC trailer and up to 3 padding bytes. After its transfer, an
//   item passes the classify stage, the queue, the back end's command register
//   and the output register. The per-sender sequence counters live in a small
//   RAM read at transfer time; a counter never written reads as zero.
//   Reset empties the queue, closes any frame and clears all sequence counters
//   at once. When the receiver stalls, the output register holds its byte,
//   the back end waits, and the queue fills before i_in.ready drops.
// ============================================================================
module escaped_frame_crc32_encoder_top #(
    parameter int NUM_SENDERS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    efce_in_if.sink    i_in,
    efce_out_if.source o_out
);
    import efce_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    // Accept and classify.
    efce_front #(
        .NUM_SENDERS (NUM_SENDERS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (front_cmd),
        .o_push  (q_push),
        .i_full  (q_full)
    );

    // Decoupling queue.
    efce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (queue_cmd),
        .o_empty (q_empty)
    );

    // Byte generation.
    efce_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (queue_cmd),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // The front end never writes a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue written while full");

    // The back end never reads an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue read while empty");

    // A frame's final byte is always the last byte of its item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_end) |-> o_out.last_of_run)
        else $error("frame end without last of run");
`endif

endmodule

>>> hw/rtl/efce_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module efce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, and read port returning the old data on a collision.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/efce_fifo.sv
// ============================================================================
// Escaped frame CRC-32 encoder command queue
// Two-entry queue of classified commands between the front and the back.
// ============================================================================
module efce_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  efce_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output efce_pkg::t_cmd o_data,
    output logic          o_empty
);
    import efce_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

>>> hw/rtl/efce_front.sv
// ============================================================================
// Escaped frame CRC-32 encoder front end
// Accepts request items, tracks the open frame and the per-sender sequence
// numbers, and queues one command per item that produces output.
// ============================================================================
module efce_front #(
    parameter int NUM_SENDERS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    efce_in_if.sink        i_in,
    output efce_pkg::t_cmd o_cmd,
    output logic           o_push,
    input  logic           i_full
);
    import efce_pkg::*;

    localparam int         IDX_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
    localparam logic [8:0] NS9   = 9'(NUM_SENDERS);

    // Sender address reduced to a counter index (address is below eight).
    function automatic logic [IDX_W-1:0] f_sender_idx(input logic [2:0] a);
        logic [8:0] r;
        r = {6'b000000, a};
        for (int k = 0; k < 8; k++) begin
            if (r >= NS9) begin
                r = r - NS9;
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // Item held in the classify stage.
    logic             r_s0_valid;
    logic             r_s0_req;
    logic [7:0]       r_s0_len;
    logic [2:0]       r_s0_addr;
    logic [7:0]       r_s0_data;
    logic             r_s0_fwd;
    logic [7:0]       r_s0_fwd_seq;
    logic             r_s0_cnt_vld;

    // Frame tracking and counter valid bits.
    logic                   r_open;
    logic [7:0]             r_remaining;
    logic [NUM_SENDERS-1:0] r_cnt_vld;

    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] s0_idx;
    logic             s0_is_start;
    logic             s0_drop;
    logic             s0_retire;
    logic             in_xfer;
    logic [7:0]       ram_rd_data;
    logic [7:0]       seq_cur;
    logic             cnt_wr;
    logic [7:0]       cnt_wr_data;
    logic [7:0]       rem_dec;

    // Classification of the held item.
    assign in_idx      = f_sender_idx(i_in.sender_address);
    assign s0_idx      = f_sender_idx(r_s0_addr);
    assign s0_is_start = (r_s0_req == REQ_START);
    assign s0_drop     = !s0_is_start && !r_open;
    assign s0_retire   = r_s0_valid && (s0_drop || !i_full);
    assign i_in.ready  = !r_s0_valid || s0_retire;
    assign in_xfer     = i_in.valid && i_in.ready;

    // Sequence number: forwarded from a write that raced the read, else the
    // stored value, else the reset value for a counter never written.
    assign seq_cur     = r_s0_fwd ? r_s0_fwd_seq : (r_s0_cnt_vld ? ram_rd_data : 8'h00);
    assign cnt_wr      = s0_retire && s0_is_start;
    assign cnt_wr_data = seq_cur + 8'd1;
    assign rem_dec     = r_remaining - 8'd1;

    // Command toward the back end.
    assign o_push       = r_s0_valid && !s0_drop && !i_full;
    assign o_cmd.kind   = s0_is_start ? CMD_START : CMD_PAYLOAD;
    assign o_cmd.close  = s0_is_start ? (r_s0_len == 8'd0) : (rem_dec == 8'd0);
    assign o_cmd.len    = r_s0_len;
    assign o_cmd.addr   = r_s0_addr;
    assign o_cmd.seq    = seq_cur;
    assign o_cmd.data   = r_s0_data;

    // Sequence counter storage.
    efce_ram #(
        .WIDTH (8),
        .DEPTH (NUM_SENDERS)
    ) u_seq_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr),
        .i_wr_addr (s0_idx),
        .i_wr_data (cnt_wr_data),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_idx),
        .o_rd_data (ram_rd_data)
    );

    // Classify stage payload, captured on each input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s0_req     <= i_in.req_type;
            r_s0_len     <= i_in.payload_length;
            r_s0_addr    <= i_in.sender_address;
            r_s0_data    <= i_in.data_byte;
            r_s0_fwd     <= cnt_wr && (s0_idx == in_idx);
            r_s0_fwd_seq <= cnt_wr_data;
            r_s0_cnt_vld <= r_cnt_vld[in_idx];
        end
    end

    // Control state: stage occupancy, open frame and counter valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
            r_cnt_vld   <= '0;
        end else begin
            if (in_xfer) begin
                r_s0_valid <= 1'b1;
            end else if (s0_retire) begin
                r_s0_valid <= 1'b0;
            end
            if (s0_retire && s0_is_start) begin
                r_open            <= (r_s0_len != 8'd0);
                r_remaining       <= r_s0_len;
                r_cnt_vld[s0_idx] <= 1'b1;
            end else if (s0_retire && !s0_drop) begin
                r_open      <= (rem_dec != 8'd0);
                r_remaining <= rem_dec;
            end
        end
    end

endmodule

>>> hw/rtl/efce_back.sv
// ============================================================================
// Escaped frame CRC-32 encoder back end
// Turns queued commands into wire bytes: header, escaped data, CRC trailer
// and zero padding, one byte per cycle into an output register while the receiver takes them.
// ============================================================================
module efce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  efce_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    efce_out_if.source     o_out
);
    import efce_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SOF,
        ST_LEN,
        ST_ADDR,
        ST_SEQ,
        ST_DATA,
        ST_CRC,
        ST_PAD
    } t_state;

    t_state               r_state,     n_state;
    t_cmd                 r_cmd,       n_cmd;
    logic                 r_esc_sent,  n_esc_sent;
    logic [31:0]          r_crc,       n_crc;
    logic [PHASE_W-1:0]   r_phase,     n_phase;
    logic [31:0]          r_fcs,       n_fcs;
    logic [CRC_IDX_W-1:0] r_crc_idx,   n_crc_idx;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_byte,  n_out_byte;
    logic                 r_out_last,  n_out_last;
    logic                 r_out_end,   n_out_end;

    logic                 busy;
    logic                 emit;
    logic [7:0]           cur_byte;
    logic                 cur_esc_ok;
    logic                 esc_now;
    logic [7:0]           emit_byte;
    logic [31:0]          crc_next;
    logic [PHASE_W-1:0]   phase_next;
    logic [31:0]          fcs_shift;
    t_state               step_state;
    logic                 done;
    logic                 frame_end;
    logic                 enter_crc;

    assign busy       = (r_state != ST_IDLE);
    assign emit       = busy && (!r_out_valid || o_out.ready);
    assign fcs_shift  = r_fcs << {r_crc_idx, 3'b000};
    assign phase_next = r_phase + PHASE_W'(1);

    // Byte owed by the current step and whether it may need an escape.
    always_comb begin
        case (r_state)
            ST_SOF: begin
                cur_byte   = START_BYTE;
                cur_esc_ok = 1'b0;
            end
            ST_LEN: begin
                cur_byte   = r_cmd.len;
                cur_esc_ok = 1'b1;
            end
            ST_ADDR: begin
                cur_byte   = {5'b00000, r_cmd.addr};
                cur_esc_ok = 1'b0;
            end
            ST_SEQ: begin
                cur_byte   = r_cmd.seq;
                cur_esc_ok = 1'b1;
            end
            ST_DATA: begin
                cur_byte   = r_cmd.data;
                cur_esc_ok = 1'b1;
            end
            ST_CRC: begin
                cur_byte   = fcs_shift[31:24];
                cur_esc_ok = 1'b1;
            end
            default: begin
                cur_byte   = 8'h00;
                cur_esc_ok = 1'b0;
            end
        endcase
    end

    assign esc_now   = cur_esc_ok && f_need_escape(cur_byte) && !r_esc_sent;
    assign emit_byte = esc_now ? ESCAPE_BYTE : cur_byte;
    assign crc_next  = f_crc_byte(r_crc, emit_byte);

    // Step sequencing once the owed byte itself goes out.
    always_comb begin
        step_state = r_state;
        done       = 1'b0;
        frame_end  = 1'b0;
        enter_crc  = 1'b0;
        case (r_state)
            ST_SOF:  step_state = ST_LEN;
            ST_LEN:  step_state = ST_ADDR;
            ST_ADDR: step_state = ST_SEQ;
            ST_SEQ, ST_DATA: begin
                if (r_cmd.close) begin
                    step_state = ST_CRC;
                    enter_crc  = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end
            ST_CRC: begin
                if (r_crc_idx == CRC_IDX_W'(CRC_BYTES - 1)) begin
                    if (phase_next == '0) begin
                        done      = 1'b1;
                        frame_end = 1'b1;
                    end else begin
                        step_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (phase_next == '0) begin
                    done      = 1'b1;
                    frame_end = 1'b1;
                end
            end
            default: step_state = ST_IDLE;
        endcase
        if (esc_now) begin
            step_state = r_state;
            done       = 1'b0;
            frame_end  = 1'b0;
            enter_crc  = 1'b0;
        end
    end

    // Take the next command when idle or as the current one finishes.
    assign o_pop = !i_empty && (!busy || (emit && done));

    // Next-state logic.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_esc_sent  = r_esc_sent;
        n_crc       = r_crc;
        n_phase     = r_phase;
        n_fcs       = r_fcs;
        n_crc_idx   = r_crc_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_end   = r_out_end;

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_byte  = emit_byte;
            n_out_last  = done;
            n_out_end   = frame_end;
            n_crc       = crc_next;
            n_phase     = phase_next;
            n_esc_sent  = esc_now;
            n_state     = step_state;
            if (enter_crc) begin
                n_fcs     = ~crc_next;
                n_crc_idx = '0;
            end else if (r_state == ST_CRC && !esc_now) begin
                n_crc_idx = r_crc_idx + CRC_IDX_W'(1);
            end
            if (frame_end) begin
                n_crc   = CRC_SEED;
                n_phase = '0;
            end
            if (done) begin
                n_state = ST_IDLE;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_cmd      = i_cmd;
            n_esc_sent = 1'b0;
            if (i_cmd.kind == CMD_START) begin
                n_state = ST_SOF;
                n_crc   = CRC_SEED;
                n_phase = '0;
            end else begin
                n_state = ST_DATA;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_esc_sent  <= 1'b0;
            r_crc       <= CRC_SEED;
            r_phase     <= '0;
            r_crc_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_esc_sent  <= n_esc_sent;
            r_crc       <= n_crc;
            r_phase     <= n_phase;
            r_crc_idx   <= n_crc_idx;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_fcs      <= n_fcs;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_end  <= n_out_end;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;
    assign o_out.frame_end   = r_out_end;

endmodule
